/* hw/rtl/hfi_pkg.sv */
// shared types and constants for the hypsometric fraction interpolator
// no dependencies; imported by the cell, the interpolation unit and the top level
package hfi_pkg;

  localparam int HFI_TABLE_POINTS = 20;
  localparam int LEVEL_W          = 32;
  localparam int FRAC_W           = 17;
  localparam int EFF_W            = LEVEL_W + 2;
  localparam int INDEX_W          = 5;
  localparam int REGION_W         = 2;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [REGION_W-1:0] {
    REGION_BELOW  = 2'd0,
    REGION_INTERP = 2'd1,
    REGION_TOP    = 2'd2
  } region_t;

  // query token that walks down the chain of table cells
  typedef struct packed {
    logic                      valid;
    logic                      pos;      // storage + offset above zero
    logic                      base;     // first cell still has to add its level
    logic                      run;      // still inside the leading run of levels <= eff
    logic                      top;      // eff at or above the level of the last cell seen
    logic signed [EFF_W-1:0]   eff;
    logic signed [LEVEL_W-1:0] lo_level;
    logic [FRAC_W-1:0]         lo_frac;
    logic signed [LEVEL_W-1:0] hi_level;
    logic [FRAC_W-1:0]         hi_frac;
  } hfi_tok_t;

endpackage

/* hw/rtl/hfi_cell.sv */
// one table cell: holds a breakpoint level and fraction, updates the passing query token
// depends on hfi_pkg
module hfi_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic signed [hfi_pkg::LEVEL_W-1:0] wr_level,
  input  logic [hfi_pkg::FRAC_W-1:0]        wr_frac,
  input  hfi_pkg::hfi_tok_t                 tok_in,
  output hfi_pkg::hfi_tok_t                 tok_out
);
  import hfi_pkg::*;

  logic signed [LEVEL_W-1:0] level;
  logic [FRAC_W-1:0]         frac;
  logic signed [EFF_W-1:0]   level_ext;
  logic signed [EFF_W-1:0]   eff_use;
  logic                      ge;
  hfi_tok_t                  tok_next;

  always_ff @(posedge clk) begin
    if (we) begin
      level <= wr_level;
      frac  <= wr_frac;
    end
  end

  always_comb begin
    level_ext = EFF_W'(level);
    eff_use   = tok_in.base ? (tok_in.eff + level_ext) : tok_in.eff;
    ge        = (eff_use >= level_ext);
    tok_next      = tok_in;
    tok_next.eff  = eff_use;
    tok_next.base = 1'b0;
    tok_next.top  = ge;
    if (tok_in.run) begin
      if (ge) begin
        tok_next.lo_level = level;
        tok_next.lo_frac  = frac;
      end else begin
        tok_next.hi_level = level;
        tok_next.hi_frac  = frac;
        tok_next.run      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* hw/rtl/hfi_interp.sv */
// interpolation unit: one multiply, then a restoring divide one quotient bit per cycle
// depends on hfi_pkg
module hfi_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  hfi_pkg::hfi_tok_t           tok,
  input  logic                        res_take,
  output logic                        res_valid,
  output logic [hfi_pkg::FRAC_W-1:0]  res_fraction,
  output hfi_pkg::region_t            res_region
);
  import hfi_pkg::*;

  localparam int PROD_W = FRAC_W + LEVEL_W;
  localparam int CNT_W  = $clog2(FRAC_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t              state;
  logic                neg;
  logic [FRAC_W-1:0]   mag;
  logic [LEVEL_W-1:0]  lvl_dist;
  logic [LEVEL_W-1:0]  span;
  logic [FRAC_W-1:0]   lo_frac;
  logic [PROD_W-1:0]   prod;
  logic [LEVEL_W:0]    rem;
  logic [FRAC_W-1:0]   dvd;
  logic [FRAC_W-1:0]   quo;
  logic [CNT_W-1:0]    cnt;

  logic signed [LEVEL_W:0]   span_w;
  logic signed [EFF_W-1:0]   dist_w;
  logic signed [FRAC_W:0]    fdiff;
  logic signed [FRAC_W:0]    fmag;
  logic [LEVEL_W:0]          rem_shift;
  logic                      rem_ge;
  logic [LEVEL_W:0]          rem_next;
  logic [FRAC_W-1:0]         quo_next;
  logic signed [FRAC_W+1:0]  sum;
  logic [FRAC_W-1:0]         sum_clamped;

  always_comb begin
    span_w = (LEVEL_W+1)'(tok.hi_level) - (LEVEL_W+1)'(tok.lo_level);
    dist_w = tok.eff - EFF_W'(tok.lo_level);
    fdiff  = $signed({1'b0, tok.hi_frac}) - $signed({1'b0, tok.lo_frac});
    fmag   = (fdiff < 0) ? -fdiff : fdiff;

    rem_shift = {rem[LEVEL_W-1:0], dvd[FRAC_W-1]};
    rem_ge    = (rem_shift >= {1'b0, span});
    rem_next  = rem_ge ? (rem_shift - {1'b0, span}) : rem_shift;
    quo_next  = {quo[FRAC_W-2:0], rem_ge};

    sum = $signed({2'b00, lo_frac})
        + (neg ? -$signed({2'b00, quo_next}) : $signed({2'b00, quo_next}));
    if (sum < 0) begin
      sum_clamped = '0;
    end else if (sum > $signed({2'b00, FRAC_ONE})) begin
      sum_clamped = FRAC_ONE;
    end else begin
      sum_clamped = sum[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      res_valid    <= 1'b0;
      res_fraction <= '0;
      res_region   <= REGION_BELOW;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (tok.valid) begin
            if (!tok.pos) begin
              res_fraction <= '0;
              res_region   <= REGION_BELOW;
              res_valid    <= 1'b1;
              state        <= ST_FIN;
            end else if (tok.top) begin
              res_fraction <= FRAC_ONE;
              res_region   <= REGION_TOP;
              res_valid    <= 1'b1;
              state        <= ST_FIN;
            end else begin
              neg      <= (fdiff < 0);
              mag      <= fmag[FRAC_W-1:0];
              lvl_dist <= dist_w[LEVEL_W-1:0];
              span     <= span_w[LEVEL_W-1:0];
              lo_frac  <= tok.lo_frac;
              state    <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(mag) * PROD_W'(lvl_dist);
          state <= ST_DSET;
        end
        ST_DSET: begin
          // high part of the product is already below the span
          rem   <= {1'b0, prod[PROD_W-1:FRAC_W]};
          dvd   <= prod[FRAC_W-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          dvd <= {dvd[FRAC_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            res_fraction <= sum_clamped;
            res_region   <= REGION_INTERP;
            res_valid    <= 1'b1;
            state        <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_take) begin
            res_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/hypsometric_fraction_interpolator_top.sv */
// top level of the hypsometric fraction interpolator: stream ports, cell chain, output register
// depends on hfi_pkg, hfi_cell and hfi_interp
//
// A write beat (tuser = 0) stores one breakpoint level and fraction in the cell chosen by
// entry_index; indexes at or beyond TABLE_POINTS are dropped and fractions above one are
// stored as one. A query beat (tuser = 1) returns one result beat. The query walks the
// chain of TABLE_POINTS cells, one cell per cycle. A query at or below zero or at the top
// gets its result as soon as it leaves the chain; one that interpolates is then captured,
// multiplied, given a divide setup and put through a 17-bit bit-serial divide before its
// result beat is valid. One query is in flight at a time and the input is held off
// meanwhile; the next beat can be accepted in the cycle after the result moves into the
// output register, so an untaken result in the output register stalls the following
// query. All table entries must be written before the first query.
module hypsometric_fraction_interpolator_top #(
  parameter int TABLE_POINTS = hfi_pkg::HFI_TABLE_POINTS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[4:0], entry_level[36:5], entry_fraction[53:37], storage[85:54],
  // level_offset[117:86], zero fill above
  input  logic [119:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fraction[16:0], zero fill above
  output logic [23:0]  m_axis_tdata,
  // region[1:0]
  output logic [1:0]   m_axis_tuser
);
  import hfi_pkg::*;

  logic [INDEX_W-1:0]        entry_index;
  logic signed [LEVEL_W-1:0] entry_level;
  logic [FRAC_W-1:0]         entry_fraction;
  logic signed [LEVEL_W-1:0] storage;
  logic signed [LEVEL_W-1:0] level_offset;
  logic [FRAC_W-1:0]         wr_frac;
  logic signed [LEVEL_W:0]   stor_sum;
  logic                      in_fire;
  logic                      wr_fire;
  logic                      query_fire;
  logic                      busy;
  logic [TABLE_POINTS-1:0]   we;
  hfi_tok_t                  tok [TABLE_POINTS+1];

  logic                 res_valid;
  logic [FRAC_W-1:0]    res_fraction;
  region_t              res_region;
  logic                 res_take;
  logic [FRAC_W-1:0]    fraction;
  region_t              region;

  assign entry_index    = s_axis_tdata[4:0];
  assign entry_level    = s_axis_tdata[36:5];
  assign entry_fraction = s_axis_tdata[53:37];
  assign storage        = s_axis_tdata[85:54];
  assign level_offset   = s_axis_tdata[117:86];

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wr_fire       = in_fire && (s_axis_tuser[0] == CMD_WRITE);
  assign query_fire    = in_fire && (s_axis_tuser[0] == CMD_QUERY);

  assign wr_frac  = (entry_fraction > FRAC_ONE) ? FRAC_ONE : entry_fraction;
  assign stor_sum = (LEVEL_W+1)'(storage) + (LEVEL_W+1)'(level_offset);

  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = query_fire;
    tok[0].pos      = (stor_sum > 0);
    tok[0].base     = 1'b1;
    tok[0].run      = 1'b1;
    tok[0].eff      = EFF_W'(stor_sum);
  end

  for (genvar i = 0; i < TABLE_POINTS; i++) begin : g_cell
    assign we[i] = wr_fire && (32'(entry_index) == i);

    hfi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .we       (we[i]),
      .wr_level (entry_level),
      .wr_frac  (wr_frac),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  hfi_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .tok          (tok[TABLE_POINTS]),
    .res_take     (res_take),
    .res_valid    (res_valid),
    .res_fraction (res_fraction),
    .res_region   (res_region)
  );

  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      fraction      <= '0;
      region        <= REGION_BELOW;
    end else begin
      if (query_fire) begin
        busy <= 1'b1;
      end else if (res_take) begin
        busy <= 1'b0;
      end
      if (res_take) begin
        m_axis_tvalid <= 1'b1;
        fraction      <= res_fraction;
        region        <= res_region;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {7'b0, fraction};
  assign m_axis_tuser = region;

endmodule
